// File: hw/rtl/pjdt_pkg.sv
`default_nettype none
package pjdt_pkg;

	localparam int unsigned TableCapacity = 1024;
	localparam int unsigned AddrW = $clog2(TableCapacity);
	localparam int unsigned CountW = $clog2(TableCapacity + 1);

	localparam int unsigned TimeW = 31;
	localparam int unsigned TagW = 32;
	localparam int unsigned IndexOutW = 10;
	localparam int unsigned CountOutW = 11;

	typedef logic [1:0] action_t;
	localparam action_t ActCheck = 2'd0;
	localparam action_t ActRemove = 2'd1;
	localparam action_t ActPurge = 2'd2;

	typedef enum logic [2:0] {
		StInserted  = 3'd0,
		StDuplicate = 3'd1,
		StFull      = 3'd2,
		StRemoved   = 3'd3,
		StNotFound  = 3'd4,
		StPurged    = 3'd5
	} status_t;

	typedef struct packed {
		logic [TagW-1:0]  tag;
		logic [TimeW-1:0] per;
		logic [TimeW-1:0] start;
	} entry_t;

	localparam int unsigned EntryW = $bits(entry_t);

endpackage
`default_nettype wire

// File: hw/rtl/periodic_job_dedup_table.sv
`default_nettype none
// Channel | Dir | Bits | Fields (lowest bit first)
// s_*     | in  | 96   | action[1:0], start_time[32:2], period[63:33], command_tag[95:64]
// m_*     | out | 24   | status[2:0], match_index[12:3], entry_count[23:13]
//
// One request word is handled at a time; s_tready is high only while the controller is idle.
// A search reads each stored entry from the table and compares it with the request; for an
// entry that is not an exact match but whose period equals a nonzero request period, the
// shared remainder unit also tests the start-time gap. Remove then moves each later entry
// down by one place; purge reads every entry and keeps only those that have not expired.
// Reset clears the entry count and the controller; the table contents need no clearing.
// A finished result waits in the output register while m_tready is low.
module periodic_job_dedup_table
	import pjdt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// action, start_time, period, command_tag
	input  wire logic [95:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status, match_index, entry_count
	output logic [23:0]      m_tdata
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SRD  = 9'b000000010,
		S_SEV  = 9'b000000100,
		S_SMOD = 9'b000001000,
		S_SHRD = 9'b000010000,
		S_SHWR = 9'b000100000,
		S_PRD  = 9'b001000000,
		S_PEV  = 9'b010000000,
		S_RES  = 9'b100000000
	} state_t;

	state_t state_q;

	// Latched request.
	action_t          act_q;
	entry_t           req_q;
	logic [CountW-1:0] count_q;
	logic [CountW-1:0] i_q;
	logic [CountW-1:0] j_q;
	logic [CountW-1:0] match_q;

	status_t           res_status_q;
	logic [CountW-1:0] res_index_q;
	logic              out_valid_q;
	logic [23:0]       out_data_q;

	// Table port signals.
	logic              ram_we;
	logic [AddrW-1:0]  ram_waddr;
	logic [EntryW-1:0] ram_wdata;
	logic [AddrW-1:0]  ram_raddr;
	logic [EntryW-1:0] ram_rdata;
	entry_t            rd_entry;

	logic              exact;
	logic              per_match;
	logic [TimeW-1:0]  gap;
	logic              rem_start;
	logic              rem_done;
	logic              rem_zero;
	logic              hit;
	logic              miss;
	logic              last_entry;
	logic              expired;

	assign rd_entry = entry_t'(ram_rdata);
	assign exact = (rd_entry == req_q);
	assign per_match = (req_q.per != '0) && (rd_entry.per == req_q.per);
	assign gap = (req_q.start >= rd_entry.start) ? (req_q.start - rd_entry.start)
		: (rd_entry.start - req_q.start);
	assign rem_start = (state_q == S_SEV) && !exact && per_match;
	assign hit = ((state_q == S_SEV) && exact) || ((state_q == S_SMOD) && rem_done && rem_zero);
	assign miss = ((state_q == S_SEV) && !exact && !per_match)
		|| ((state_q == S_SMOD) && rem_done && !rem_zero);
	assign last_entry = ((i_q + 1'b1) == count_q);
	assign expired = (rd_entry.per == '0) && (rd_entry.start <= req_q.start);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = i_q[AddrW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = i_q[AddrW-1:0];
		unique case (state_q)
			S_SRD: begin
				// Append on a clean miss while there is room.
				if (i_q == count_q && act_q == ActCheck
						&& count_q != CountW'(TableCapacity)) begin
					ram_we    = 1'b1;
					ram_waddr = count_q[AddrW-1:0];
					ram_wdata = req_q;
				end
			end
			S_SHRD: begin
				ram_raddr = AddrW'(i_q + 1'b1);
			end
			S_SHWR: begin
				ram_we = 1'b1;
			end
			S_PEV: begin
				ram_we    = !expired;
				ram_waddr = j_q[AddrW-1:0];
			end
			default: begin
			end
		endcase
	end

	pjdt_ram #(
		.Depth(TableCapacity),
		.Width(EntryW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pjdt_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (gap),
		.divisor  (req_q.per),
		.done     (rem_done),
		.rem_zero (rem_zero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			match_q      <= '0;
			act_q        <= ActCheck;
			req_q        <= '0;
			res_status_q <= StNotFound;
			res_index_q  <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
		end else begin
			// The result state refills the register itself whenever the sink takes the word.
			if (m_tready && state_q != S_RES) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						act_q     <= s_tdata[1:0];
						req_q     <= {s_tdata[95:64], s_tdata[63:33], s_tdata[32:2]};
						i_q       <= '0;
						j_q       <= '0;
						res_index_q <= '0;
						if (s_tdata[1:0] == ActCheck || s_tdata[1:0] == ActRemove) begin
							state_q <= S_SRD;
						end else if (s_tdata[1:0] == ActPurge) begin
							state_q <= S_PRD;
						end else begin
							res_status_q <= StNotFound;
							state_q      <= S_RES;
						end
					end
				end
				S_SRD: begin
					if (i_q == count_q) begin
						// No entry matched.
						if (act_q == ActRemove) begin
							res_status_q <= StNotFound;
						end else if (count_q == CountW'(TableCapacity)) begin
							res_status_q <= StFull;
						end else begin
							res_status_q <= StInserted;
							res_index_q  <= count_q;
							count_q      <= count_q + 1'b1;
						end
						state_q <= S_RES;
					end else begin
						state_q <= S_SEV;
					end
				end
				S_SEV, S_SMOD: begin
					if (hit) begin
						if (act_q == ActRemove) begin
							match_q <= i_q;
							state_q <= S_SHRD;
						end else begin
							res_status_q <= StDuplicate;
							res_index_q  <= i_q;
							state_q      <= S_RES;
						end
					end else if (miss) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SRD;
					end else begin
						state_q <= S_SMOD;
					end
				end
				S_SHRD: begin
					if (last_entry) begin
						count_q      <= count_q - 1'b1;
						res_status_q <= StRemoved;
						res_index_q  <= match_q;
						state_q      <= S_RES;
					end else begin
						state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_SHRD;
				end
				S_PRD: begin
					if (i_q == count_q) begin
						count_q      <= j_q;
						res_status_q <= StPurged;
						state_q      <= S_RES;
					end else begin
						state_q <= S_PEV;
					end
				end
				S_PEV: begin
					if (!expired) begin
						j_q <= j_q + 1'b1;
					end
					i_q     <= i_q + 1'b1;
					state_q <= S_PRD;
				end
				S_RES: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {CountOutW'(count_q), IndexOutW'(res_index_q),
							res_status_q};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
`default_nettype wire

// File: hw/rtl/pjdt_ram.sv
`default_nettype none
module pjdt_ram #(
	parameter int unsigned Depth = 1024,
	parameter int unsigned Width = 94,
	parameter int unsigned AW = $clog2(Depth)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [Width-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: hw/rtl/pjdt_rem.sv
`default_nettype none
// Restoring remainder unit, one quotient bit per cycle.
module pjdt_rem
	import pjdt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [TimeW-1:0] dividend,
	input  wire logic [TimeW-1:0] divisor,
	output logic                  done,
	output logic                  rem_zero
);

	localparam int unsigned CntW = $clog2(TimeW + 1);

	logic [TimeW-1:0] rem_q;
	logic [TimeW-1:0] dvd_q;
	logic [TimeW-1:0] dvs_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [TimeW:0]   shifted;
	logic [TimeW:0]   diff;

	assign shifted = {rem_q, dvd_q[TimeW-1]};
	assign diff = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(TimeW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (!diff[TimeW]) begin
				rem_q <= diff[TimeW-1:0];
			end else begin
				rem_q <= shifted[TimeW-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem_zero = (rem_q == '0);

endmodule
`default_nettype wire

// File: tb/pjdt_checker.sv
module pjdt_checker
	import pjdt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	// action, start_time, period, command_tag
	input  wire logic [95:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	// status, match_index, entry_count
	input  wire logic [23:0] m_tdata,
	output int               fail_count,
	output int               pending,
	output int               job_total
);

	typedef struct {
		status_t     status;
		logic [9:0]  index;
		logic [10:0] count;
	} outcome_t;

	entry_t   job_table[$];
	outcome_t outcome_q[$];

	// A stored job collides with a request on an exact match, or when both
	// repeat with the same nonzero period and their start times line up.
	function automatic bit job_collides(entry_t e, logic [30:0] st, logic [30:0] pe,
			logic [31:0] tg);
		logic [30:0] gap;
		if (e.start == st && e.per == pe && e.tag == tg)
			return 1'b1;
		if (pe != '0 && e.per == pe) begin
			gap = (st >= e.start) ? st - e.start : e.start - st;
			return (gap % pe) == '0;
		end
		return 1'b0;
	endfunction

	function automatic outcome_t schedule_update(logic [95:0] word);
		action_t     act;
		logic [30:0] st;
		logic [30:0] pe;
		logic [31:0] tg;
		int          hit;
		outcome_t    o;
		entry_t      kept[$];
		entry_t      e;
		act = word[1:0];
		st = word[32:2];
		pe = word[63:33];
		tg = word[95:64];
		o.status = StNotFound;
		o.index = '0;
		hit = -1;
		foreach (job_table[i])
			if (hit < 0 && job_collides(job_table[i], st, pe, tg))
				hit = i;
		case (act)
			ActCheck: begin
				if (hit >= 0) begin
					o.status = StDuplicate;
					o.index = hit[9:0];
				end else if (job_table.size() >= TableCapacity) begin
					o.status = StFull;
				end else begin
					e.start = st;
					e.per = pe;
					e.tag = tg;
					job_table.push_back(e);
					o.status = StInserted;
					o.index = 10'(job_table.size() - 1);
				end
			end
			ActRemove: begin
				if (hit >= 0) begin
					job_table.delete(hit);
					o.status = StRemoved;
					o.index = hit[9:0];
				end
			end
			ActPurge: begin
				foreach (job_table[i])
					if (!(job_table[i].per == '0 && job_table[i].start <= st))
						kept.push_back(job_table[i]);
				job_table = kept;
				o.status = StPurged;
			end
			default: ;
		endcase
		o.count = 11'(job_table.size());
		return o;
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
		job_total = 0;
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: result word %h arrived with nothing expected", $time, m_tdata);
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					if (m_tdata[2:0] != want.status || m_tdata[12:3] != want.index
							|| m_tdata[23:13] != want.count) begin
						$display("%0t: mismatch expected status %0d index %0d count %0d, got status %0d index %0d count %0d",
							$time, want.status, want.index, want.count,
							m_tdata[2:0], m_tdata[12:3], m_tdata[23:13]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				outcome_q.push_back(schedule_update(s_tdata));
		end
		pending = outcome_q.size();
		job_total = job_table.size();
	end

endmodule

// File: tb/tb_periodic_job_dedup_table.sv
module tb_periodic_job_dedup_table;
	import pjdt_pkg::*;

	localparam int StallLimit = 200000;
	localparam int RandomWords = 524;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// action, start_time, period, command_tag
	logic [95:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// status, match_index, entry_count
	logic [23:0] m_tdata;

	int fail_count;
	int pending;
	int job_total;

	// Test-side controls: quiet turns idling off on both sides, and
	// hold_req asks the receiver for one long back-pressure window.
	bit quiet;
	bit hold_req;
	int words_sent;
	int idle_run;

	// Recently offered jobs, so that random words can aim at stored entries.
	entry_t recent_jobs[$];

	periodic_job_dedup_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	pjdt_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.fail_count(fail_count),
		.pending(pending),
		.job_total(job_total)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Offer one request word. It may be preceded by a short idle gap; the
	// word is then held until the block takes it at a rising edge.
	task automatic send_word(action_t act, logic [30:0] st, logic [30:0] pe, logic [31:0] tg);
		int gap;
		if (!quiet && $urandom_range(0, 99) < 36) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {tg, pe, st, act};
		forever begin
			@(negedge clk);
			if (s_tready)
				break;
		end
		@(posedge clk);
		words_sent++;
	endtask

	// Wait until the checker has no result outstanding; the first falling
	// edge lets the checker record a word accepted at the last rising edge.
	task automatic drain_results();
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic logic [30:0] pick_period();
		int r;
		int unsigned pool[6] = '{1, 2, 3, 7, 60, 3600};
		r = $urandom_range(0, 99);
		if (r < 30)
			return '0;
		if (r < 70)
			return 31'(pool[$urandom_range(0, 5)]);
		return 31'($urandom);
	endfunction

	// One random request. Many words are built around jobs offered earlier,
	// so duplicates, aligned repeats and removals of stored entries are
	// frequent; the rest is fresh jobs, purges and the unused action code.
	task automatic send_random();
		int     r;
		entry_t h;
		entry_t j;
		logic [30:0] k;
		r = $urandom_range(0, 99);
		// A growing table slows every search, so lean toward shrinking it.
		if (job_total > 20 && r < 50)
			r = 50 + r / 2;
		if (recent_jobs.size() != 0)
			h = recent_jobs[$urandom_range(0, recent_jobs.size() - 1)];
		else
			h = '{tag: $urandom, per: pick_period(), start: 31'($urandom)};
		k = 31'($urandom_range(0, 5));
		if (r < 35 || (r >= 90)) begin
			j.start = 31'($urandom);
			j.per = (r >= 90) ? 31'($urandom) : pick_period();
			j.tag = $urandom;
			recent_jobs.push_back(j);
			if (recent_jobs.size() > 16)
				void'(recent_jobs.pop_front());
			send_word(ActCheck, j.start, j.per, j.tag);
		end else if (r < 50) begin
			if ($urandom_range(0, 1))
				send_word(ActCheck, h.start, h.per, h.tag);
			else
				send_word(ActCheck, h.start + k * h.per, h.per, $urandom);
		end else if (r < 70) begin
			case ($urandom_range(0, 2))
				0: send_word(ActRemove, h.start, h.per, h.tag);
				1: send_word(ActRemove, h.start - k * h.per, h.per, $urandom);
				default: send_word(ActRemove, 31'($urandom), pick_period(), $urandom);
			endcase
		end else if (r < 85) begin
			case ($urandom_range(0, 2))
				0: send_word(ActPurge, h.start, 31'($urandom), $urandom);
				1: send_word(ActPurge, 31'h7fffffff, 31'($urandom), $urandom);
				default: send_word(ActPurge, 31'($urandom), 31'($urandom), $urandom);
			endcase
		end else begin
			send_word(action_t'(2'd3), 31'($urandom), 31'($urandom), $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		words_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: field extremes, both match rules, each action,
		// a missed removal, the unused action code and purges at the edge.
		send_word(ActCheck, '0, '0, '0);
		send_word(ActCheck, '0, '0, '0);
		send_word(ActCheck, 31'h7fffffff, 31'h7fffffff, 32'hffffffff);
		send_word(ActCheck, 31'd10, 31'd5, 32'd1);
		send_word(ActCheck, 31'd25, 31'd5, 32'd2);
		send_word(ActCheck, 31'd3, 31'd5, 32'd1);
		send_word(ActRemove, 31'd30, 31'd5, 32'd9);
		send_word(ActRemove, 31'd1, 31'd0, 32'd1);
		send_word(action_t'(2'd3), 31'h7fffffff, 31'h7fffffff, 32'hffffffff);
		send_word(ActCheck, 31'd100, 31'd0, 32'd7);
		send_word(ActPurge, 31'd50, '0, '0);
		send_word(ActPurge, 31'd100, '0, '0);
		send_word(ActCheck, 31'h7fffffff, 31'd1, 32'h0);
		send_word(ActCheck, 31'd0, 31'd1, 32'd5);
		send_word(ActRemove, 31'h7fffffff, 31'h7fffffff, 32'hffffffff);
		send_word(ActRemove, 31'd3, 31'd5, 32'd1);
		s_tvalid <= 1'b0;
		drain_results();
		@(posedge clk);

		for (int i = 0; i < RandomWords; i++) begin
			if (i == 60)
				hold_req = 1'b1;
			quiet = (i >= 150 && i < 250);
			if (i == 300) begin
				s_tvalid <= 1'b0;
				drain_results();
				@(posedge clk);
			end
			send_random();
		end
		s_tvalid <= 1'b0;
		quiet = 1'b0;

		drain_results();
		repeat (100) @(posedge clk);
		$display("Sent %0d request words: directed edge cases, then random inserts,",
			words_sent);
		$display("duplicates, removals and purges under random and long output stalls.");
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// The receiver stalls at random, except for one long hold that lets the
	// block fill its output register and block the request side.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= quiet || ($urandom_range(0, 99) >= 36);
			end
		end
	end

	// Watchdog: counts cycles in which no word moves on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_run <= 0;
		end else if (idle_run >= StallLimit) begin
			$display("Timeout: no word moved for %0d cycles", StallLimit);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

endmodule
